@@ hdl/gbs_pkg.sv @@
// gradient box shader package: widths, register indexes, mode codes and shared types
package gbs_pkg;

	localparam int COORD_BITS = 12;
	localparam int DIM_BITS = 13;
	localparam int DIFF_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
	localparam int G_BITS = 17;
	localparam int G_FRAC = 16;
	localparam logic [G_BITS-1:0] G_MAX = {G_BITS{1'b1}};
	localparam int QUO_BITS = 17;
	localparam int SQ_BITS = 36;
	localparam int ROOT_STEPS = 18;
	localparam int ROOT_BITS = 18;
	localparam logic [15:0] DIST_SCALE = 16'd58982;
	localparam int COLOR_BITS = 24;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 24;
	localparam int MODE_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LEFT = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_TOP = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_WIDTH = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAIN_COLOR = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_COLOR = 3'd6;

	localparam logic [MODE_BITS-1:0] MODE_ROWS = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_COLS = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_DIAG = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_CTR_ROWS = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_CTR_COLS = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_CTR_BOTH = 3'd5;
	localparam logic [MODE_BITS-1:0] MODE_DIST = 3'd6;
	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 3'd7;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} coord_t;

	typedef struct packed {
		coord_t pos;
		logic [G_BITS-1:0] g;
	} side_t;

endpackage

@@ hdl/gbs_div_pipe.sv @@
// two-lane pipelined restoring divider producing the column and row weight terms
module gbs_div_pipe (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [gbs_pkg::COORD_BITS-1:0] col,
	input logic [gbs_pkg::COORD_BITS-1:0] row,
	input logic [gbs_pkg::DIM_BITS-1:0] width,
	input logic [gbs_pkg::DIM_BITS-1:0] height,
	input logic center,
	input gbs_pkg::coord_t pos_in,
	output logic out_valid,
	output logic [gbs_pkg::G_BITS-1:0] term_col,
	output logic [gbs_pkg::G_BITS-1:0] term_row,
	output gbs_pkg::coord_t pos_out
);

	localparam int DB = gbs_pkg::DIM_BITS;
	localparam int FB = gbs_pkg::DIFF_BITS;
	localparam int QB = gbs_pkg::QUO_BITS;

	logic [DB-1:0] den_w [2];
	logic zero_w [2];
	logic [FB-1:0] num_w [2];
	logic sat_w [2];

	logic [DB:0] rem_s [2][QB+1];
	logic [QB-1:0] quo_s [2][QB+1];
	logic sat_s [2][QB+1];
	logic vld_s [QB+1];
	gbs_pkg::coord_t pos_s [QB+1];

	always_comb begin
		logic [gbs_pkg::COORD_BITS-1:0] a;
		logic [DB-1:0] n;
		logic [FB-1:0] ax;
		logic [FB-1:0] hx;
		for (int l = 0; l < 2; l++) begin
			a = (l == 0) ? col : row;
			n = (l == 0) ? width : height;
			den_w[l] = center ? {1'b0, n[DB-1:1]} : n;
			zero_w[l] = (den_w[l] == '0);
			ax = FB'(a);
			hx = FB'(den_w[l]);
			if (center) begin
				num_w[l] = (hx > ax) ? (hx - ax) : (ax - hx);
			end else begin
				num_w[l] = ax;
			end
			sat_w[l] = ((FB+1)'(num_w[l]) >= (FB+1)'({den_w[l], 1'b0}));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				rem_s[l][0] <= num_w[l][DB:0];
				quo_s[l][0] <= '0;
				sat_s[l][0] <= sat_w[l];
			end
			pos_s[0] <= pos_in;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar k = 0; k < QB; k++) begin : g_step
			logic [DB:0] t;
			logic [DB:0] d;
			logic ge;
			always_comb begin
				if (k == 0) begin
					t = rem_s[l][k];
				end else begin
					t = {rem_s[l][k][DB-1:0], 1'b0};
				end
				d = {1'b0, den_w[l]};
				ge = (t >= d);
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l][k+1] <= ge ? (t - d) : t;
					quo_s[l][k+1] <= {quo_s[l][k][QB-2:0], ge};
					sat_s[l][k+1] <= sat_s[l][k];
				end
			end
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				pos_s[k+1] <= pos_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < QB; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_comb begin
		if (zero_w[0]) begin
			term_col = '0;
		end else if (sat_s[0][QB]) begin
			term_col = gbs_pkg::G_MAX;
		end else begin
			term_col = quo_s[0][QB];
		end
		if (zero_w[1]) begin
			term_row = '0;
		end else if (sat_s[1][QB]) begin
			term_row = gbs_pkg::G_MAX;
		end else begin
			term_row = quo_s[1][QB];
		end
	end

	assign out_valid = vld_s[QB];
	assign pos_out = pos_s[QB];

endmodule

@@ hdl/gbs_sqrt_pipe.sv @@
// distance weight pipeline: squares, sum, stepwise square root and 0.9 scaling
module gbs_sqrt_pipe (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [gbs_pkg::G_BITS-1:0] term_a,
	input logic [gbs_pkg::G_BITS-1:0] term_b,
	input gbs_pkg::side_t side_in,
	output logic out_valid,
	output logic [gbs_pkg::G_BITS-1:0] g_dist,
	output gbs_pkg::side_t side_out
);

	localparam int SB = gbs_pkg::SQ_BITS;
	localparam int RS = gbs_pkg::ROOT_STEPS;
	localparam int GB = gbs_pkg::G_BITS;
	localparam int NS = RS + 3;

	logic [2*GB-1:0] sqa_s1;
	logic [2*GB-1:0] sqb_s1;
	logic [SB-1:0] rem_s [RS+1];
	logic [SB-1:0] root_s [RS+1];
	logic [gbs_pkg::ROOT_BITS+15:0] scl_s3;
	logic vld_s [NS];
	gbs_pkg::side_t side_s [NS];

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s1 <= term_a * term_a;
			sqb_s1 <= term_b * term_b;
			rem_s[0] <= SB'(sqa_s1) + SB'(sqb_s1);
			root_s[0] <= '0;
			scl_s3 <= root_s[RS][gbs_pkg::ROOT_BITS-1:0] * gbs_pkg::DIST_SCALE;
		end
	end

	for (genvar k = 0; k < RS; k++) begin : g_root
		logic [SB-1:0] bitv;
		logic [SB-1:0] tb;
		logic ge;
		always_comb begin
			bitv = SB'(1) << (SB - 2 - 2 * k);
			tb = root_s[k] + bitv;
			ge = (rem_s[k] >= tb);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? (rem_s[k] - tb) : rem_s[k];
				root_s[k+1] <= ge ? ((root_s[k] >> 1) + bitv) : (root_s[k] >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 0; k < NS - 1; k++) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < NS - 1; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_comb begin
		if (scl_s3[gbs_pkg::ROOT_BITS+15:16] > (gbs_pkg::ROOT_BITS)'(gbs_pkg::G_MAX)) begin
			g_dist = gbs_pkg::G_MAX;
		end else begin
			g_dist = scl_s3[GB+15:16];
		end
	end

	assign out_valid = vld_s[NS-1];
	assign side_out = side_s[NS-1];

endmodule

@@ hdl/gbs_blend.sv @@
// output stage: per-channel color blend with clamping, registered toward the receiver
module gbs_blend (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [gbs_pkg::G_BITS-1:0] g,
	input gbs_pkg::coord_t pos,
	input logic [gbs_pkg::COLOR_BITS-1:0] main_color,
	input logic [gbs_pkg::COLOR_BITS-1:0] second_color,
	output logic out_valid,
	output logic [gbs_pkg::COORD_BITS-1:0] pixel_x,
	output logic [gbs_pkg::COORD_BITS-1:0] pixel_y,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	function automatic logic [7:0] mix(input logic [7:0] m, input logic [7:0] s,
			input logic [gbs_pkg::G_BITS-1:0] w);
		logic signed [9:0] dlt;
		logic signed [27:0] prod;
		logic signed [27:0] acc;
		dlt = $signed({2'b00, s}) - $signed({2'b00, m});
		prod = dlt * $signed({1'b0, w});
		acc = $signed({4'b0000, m, 16'h0000}) + prod;
		if (acc < 0) begin
			mix = 8'd0;
		end else if (acc[27:16] > 12'd255) begin
			mix = 8'd255;
		end else begin
			mix = acc[23:16];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_x <= pos.x;
			pixel_y <= pos.y;
			red <= mix(main_color[23:16], second_color[23:16], g);
			green <= mix(main_color[15:8], second_color[15:8], g);
			blue <= mix(main_color[7:0], second_color[7:0], g);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

endmodule

@@ hdl/gradient_box_shader.sv @@
// gradient box shader top level: configuration registers, weight select and pipeline
//
// Colors one pixel of a gradient-filled box per item. Box position, size, gradient
// mode and the two colors are written through cfg_write/cfg_index/cfg_data. The user
// must write them only while no item is in flight; the block does not enforce this.
// An input item (col_offset, row_offset) is taken when in_valid and in_ready are
// high; a result item (pixel_x, pixel_y, red, green, blue) is handed over when
// out_valid and out_ready are high. An item passes the divider stages, the squares,
// the 18-step root, the scaling and the blend register in that order.
// Throughput is one item per cycle while the receiver does not stall, set by the
// one-bit-per-stage divider and one-step-per-stage root pipelines.
// Reset clears all valid bits and loads the registers with their defaults
// (width and height 1, all else 0).
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
module gradient_box_shader (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [gbs_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [gbs_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [gbs_pkg::COORD_BITS-1:0] col_offset,
	input logic [gbs_pkg::COORD_BITS-1:0] row_offset,
	output logic out_valid,
	input logic out_ready,
	output logic [gbs_pkg::COORD_BITS-1:0] pixel_x,
	output logic [gbs_pkg::COORD_BITS-1:0] pixel_y,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	localparam int GB = gbs_pkg::G_BITS;

	logic [gbs_pkg::COORD_BITS-1:0] box_left_q;
	logic [gbs_pkg::COORD_BITS-1:0] box_top_q;
	logic [gbs_pkg::DIM_BITS-1:0] box_width_q;
	logic [gbs_pkg::DIM_BITS-1:0] box_height_q;
	logic [gbs_pkg::MODE_BITS-1:0] mode_q;
	logic [gbs_pkg::COLOR_BITS-1:0] main_color_q;
	logic [gbs_pkg::COLOR_BITS-1:0] second_color_q;

	logic en;
	logic center;
	gbs_pkg::coord_t pos_in;
	logic div_valid;
	logic [GB-1:0] term_col;
	logic [GB-1:0] term_row;
	gbs_pkg::coord_t div_pos;
	gbs_pkg::side_t side_in;
	logic [GB:0] term_sum;
	logic sq_valid;
	logic [GB-1:0] g_dist;
	gbs_pkg::side_t sq_side;
	logic [GB-1:0] g_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q <= '0;
			box_top_q <= '0;
			box_width_q <= gbs_pkg::DIM_BITS'(1);
			box_height_q <= gbs_pkg::DIM_BITS'(1);
			mode_q <= gbs_pkg::MODE_ROWS;
			main_color_q <= '0;
			second_color_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				gbs_pkg::REG_BOX_LEFT: box_left_q <= cfg_data[gbs_pkg::COORD_BITS-1:0];
				gbs_pkg::REG_BOX_TOP: box_top_q <= cfg_data[gbs_pkg::COORD_BITS-1:0];
				gbs_pkg::REG_BOX_WIDTH: box_width_q <= cfg_data[gbs_pkg::DIM_BITS-1:0];
				gbs_pkg::REG_BOX_HEIGHT: box_height_q <= cfg_data[gbs_pkg::DIM_BITS-1:0];
				gbs_pkg::REG_MODE: mode_q <= cfg_data[gbs_pkg::MODE_BITS-1:0];
				gbs_pkg::REG_MAIN_COLOR: main_color_q <= cfg_data[gbs_pkg::COLOR_BITS-1:0];
				gbs_pkg::REG_SECOND_COLOR: second_color_q <= cfg_data[gbs_pkg::COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	assign center = (mode_q == gbs_pkg::MODE_CTR_ROWS) || (mode_q == gbs_pkg::MODE_CTR_COLS)
		|| (mode_q == gbs_pkg::MODE_CTR_BOTH) || (mode_q == gbs_pkg::MODE_DIST);

	assign pos_in.x = box_left_q + col_offset;
	assign pos_in.y = box_top_q + row_offset;

	gbs_div_pipe u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.col(col_offset),
		.row(row_offset),
		.width(box_width_q),
		.height(box_height_q),
		.center(center),
		.pos_in(pos_in),
		.out_valid(div_valid),
		.term_col(term_col),
		.term_row(term_row),
		.pos_out(div_pos)
	);

	assign term_sum = {1'b0, term_col} + {1'b0, term_row};

	always_comb begin
		side_in.pos = div_pos;
		case (mode_q)
			gbs_pkg::MODE_ROWS: side_in.g = term_row;
			gbs_pkg::MODE_COLS: side_in.g = term_col;
			gbs_pkg::MODE_DIAG: side_in.g = term_sum[GB:1];
			gbs_pkg::MODE_CTR_ROWS: side_in.g = term_row;
			gbs_pkg::MODE_CTR_COLS: side_in.g = term_col;
			gbs_pkg::MODE_CTR_BOTH: side_in.g = term_sum[GB:1];
			default: side_in.g = '0;
		endcase
	end

	gbs_sqrt_pipe u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(div_valid),
		.term_a(term_col),
		.term_b(term_row),
		.side_in(side_in),
		.out_valid(sq_valid),
		.g_dist(g_dist),
		.side_out(sq_side)
	);

	assign g_fin = (mode_q == gbs_pkg::MODE_DIST) ? g_dist : sq_side.g;

	gbs_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(sq_valid),
		.g(g_fin),
		.pos(sq_side.pos),
		.main_color(main_color_q),
		.second_color(second_color_q),
		.out_valid(out_valid),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.red(red),
		.green(green),
		.blue(blue)
	);

	a_equal_colors: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (main_color_q == second_color_q))
		|-> ({red, green, blue} == main_color_q))
		else $error("equal colors must give the base color");

	a_unused_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (mode_q == gbs_pkg::MODE_UNUSED))
		|-> ({red, green, blue} == main_color_q))
		else $error("unused mode must give the base color");

	a_zero_dims: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (box_width_q == '0) && (box_height_q == '0))
		|-> ({red, green, blue} == main_color_q))
		else $error("zero-size box must give the base color");

endmodule
